// ----- rtl/odmhh_pkg.sv -----
// shared types, constants and tables for the omni drive mixer
`default_nettype none
package odmhh_pkg;

  localparam int XW = 34;
  localparam int ZW = 32;
  localparam int WW = 26;
  localparam int OUT_W = 48;
  localparam int MAX_STEPS = 24;

  localparam logic signed [XW-1:0] KINV_Q30 = 34'sd652032874;
  localparam logic signed [XW-1:0] ONE_Q30 = 34'sd1073741824;
  localparam logic [14:0] PI_Q13 = 15'd25736;
  localparam logic [19:0] SCALE_X = 20'd819200;

  localparam logic [1:0] REG_DRIVE_LIMIT = 2'd0;
  localparam logic [1:0] REG_ERROR_SCALE = 2'd1;
  localparam logic [1:0] REG_SETTLE_BAND = 2'd2;

  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_FORWARD = 2'd1;
  localparam logic [1:0] MODE_LEFT = 2'd2;
  localparam logic [1:0] MODE_RIGHT = 2'd3;

  localparam logic signed [ZW-1:0] ATAB [MAX_STEPS] = '{
    32'sd4915200, 32'sd2901612, 32'sd1533132, 32'sd778242,
    32'sd390631, 32'sd195506, 32'sd97777, 32'sd48891,
    32'sd24446, 32'sd12223, 32'sd6112, 32'sd3056,
    32'sd1528, 32'sd764, 32'sd382, 32'sd191,
    32'sd95, 32'sd48, 32'sd24, 32'sd12,
    32'sd6, 32'sd3, 32'sd1, 32'sd1
  };

  typedef struct packed {
    logic start;
    logic vec;
  } cordic_cmd_t;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_ATAN   = 7'b0000010,
    ST_REDUCE = 7'b0000100,
    ST_ROT    = 7'b0001000,
    ST_MUL    = 7'b0010000,
    ST_WHEEL  = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/odmhh_cordic.sv -----
// iterative cordic shared by the arctangent and the sine-cosine passes
`default_nettype none
module odmhh_cordic import odmhh_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cordic_cmd_t          cmd,
  input  wire logic signed [XW-1:0] x0,
  input  wire logic signed [XW-1:0] y0,
  input  wire logic signed [ZW-1:0] z0,
  output logic                      busy,
  output logic signed [XW-1:0]      x,
  output logic signed [XW-1:0]      y,
  output logic signed [ZW-1:0]      z
);

  localparam int NSTEP = (CORDIC_STEPS < MAX_STEPS) ? CORDIC_STEPS : MAX_STEPS;

  logic signed [XW-1:0] x_r, y_r, x_nxt, y_nxt;
  logic signed [ZW-1:0] z_r, z_nxt, t;
  logic [4:0] cnt_r;
  logic vec_r, busy_r, sigma;

  always_comb begin
    t = vec_r ? ATAB[cnt_r] : ((ATAB[cnt_r] <<< 6) - (ATAB[cnt_r] <<< 2));
    sigma = vec_r ? y_r[XW-1] : !z_r[ZW-1];
    if (sigma) begin
      x_nxt = x_r - (y_r >>> cnt_r);
      y_nxt = y_r + (x_r >>> cnt_r);
      z_nxt = z_r - t;
    end else begin
      x_nxt = x_r + (y_r >>> cnt_r);
      y_nxt = y_r - (x_r >>> cnt_r);
      z_nxt = z_r + t;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
      vec_r <= 1'b0;
    end else if (cmd.start) begin
      busy_r <= 1'b1;
      cnt_r <= '0;
      vec_r <= cmd.vec;
    end else if (busy_r) begin
      if (cnt_r == 5'(NSTEP - 1)) busy_r <= 1'b0;
      else cnt_r <= cnt_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      x_r <= x0;
      y_r <= y0;
      z_r <= z0;
    end else if (busy_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign busy = busy_r;
  assign x = x_r;
  assign y = y_r;
  assign z = z_r;

endmodule
`default_nettype wire

// ----- rtl/omni_drive_mixer_heading_hold.sv -----
// top level: four-wheel omni mixer with field-oriented drive and heading hold
// One control tick is taken at a time. A tick runs through these steps from one transfer
// to the next: taking the tick, an arctangent pass when a heading-hold turn is active,
// quarter-turn reduction, a sine-cosine pass unless the reduced angle is zero, the stick
// products on the single stick multiplier, wheel mixing and the load of the output register,
// all on one shared CORDIC unit and one multiplier under a small sequencer. A finished
// result waits in the output register while the next tick is accepted; a second finished
// result waits until the first is taken. Configuration writes are always taken.
`default_nettype none
module omni_drive_mixer_heading_hold import odmhh_pkg::*; #(
  parameter int CORDIC_STEPS = 16,
  parameter int STICK_BITS = 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  // stick_x, stick_y, left_trigger, right_trigger, heading_cdeg, stop_press,
  // manual_turn, turn_request, half_speed, clear_flags
  input  wire logic [((2*STICK_BITS+38+7)/8)*8-1:0] in_tdata,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  // wheel_a, wheel_b, wheel_c, wheel_d, turn_rate, rear_facing
  output logic [OUT_W-1:0]               out_tdata,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [9:0]                cfg_data
);

  localparam int SB = STICK_BITS;
  localparam int AW = SB + 36;
  localparam int XXW = SB + 2;
  localparam int VW = SB + 21;

  state_t state_r;
  logic [7:0] lim_r, scale_r;
  logic [9:0] band_r;
  logic rear_r, rl_r, rr_r;
  logic signed [15:0] prev_r;
  logic [1:0] mode_r;

  logic signed [SB-1:0] rx_r, ry_r;
  logic half_r, r_r, neg_r, start_r;
  logic signed [17:0] a_r;
  logic [17:0] emag_r;
  logic [1:0] q_r, cnt_r;
  logic signed [WW-1:0] w_r;
  logic signed [XW-2:0] c_r, s_r;
  logic signed [AW-1:0] acc_r;
  logic signed [XXW-1:0] xx_r, yy_r;
  logic [8:0] wh_r [4];
  logic out_valid_r;
  logic [OUT_W-1:0] out_data_r;

  // input fields
  logic signed [SB-1:0] i_rx, i_ry;
  logic [7:0] i_lt, i_rt;
  logic signed [15:0] i_h;
  logic i_stop, i_man, i_half, i_clr;
  logic [1:0] i_req;
  assign i_rx = in_tdata[SB-1:0];
  assign i_ry = in_tdata[2*SB-1:SB];
  assign i_lt = in_tdata[2*SB+7:2*SB];
  assign i_rt = in_tdata[2*SB+15:2*SB+8];
  assign i_h = in_tdata[2*SB+31:2*SB+16];
  assign i_stop = in_tdata[2*SB+32];
  assign i_man = in_tdata[2*SB+33];
  assign i_req = in_tdata[2*SB+35:2*SB+34];
  assign i_half = in_tdata[2*SB+36];
  assign i_clr = in_tdata[2*SB+37];

  logic accept;
  assign in_tready = (state_r == ST_IDLE);
  assign accept = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // tick decode
  logic signed [17:0] h, p, b, e;
  logic wrap_pos, wrap_neg, rf, rlf, rrf, mode_end, need_atan;
  logic [1:0] m1, mode_nxt;
  logic signed [WW-1:0] w_init;

  always_comb begin
    h = 18'(i_h);
    p = 18'(prev_r);
    b = 18'(signed'({1'b0, band_r}));
    rf = rear_r;
    rlf = rl_r;
    rrf = rr_r;
    wrap_pos = (p > 18'sd17000) && (h < 18'sd1000);
    wrap_neg = (p < -18'sd17000) && (h > -18'sd1000);
    priority if (!rear_r) begin
      if (wrap_pos) begin
        rf = 1'b1;
        rlf = 1'b1;
      end else if (wrap_neg) begin
        rf = 1'b1;
        rrf = 1'b1;
      end
    end else if (wrap_pos || wrap_neg) begin
      rf = 1'b0;
      rlf = 1'b0;
      rrf = 1'b0;
    end else if (p >= 0 && p < 18'sd1000 && h < 0 && h > -18'sd1000) begin
      if (!rl_r) rf = 1'b0;
      else begin
        rrf = 1'b1;
        rlf = 1'b0;
      end
    end else if (p <= 0 && p > -18'sd1000 && h > 0 && h < 18'sd1000) begin
      if (!rr_r) rf = 1'b0;
      else begin
        rlf = 1'b1;
        rrf = 1'b0;
      end
    end
    m1 = (i_req != MODE_NONE) ? i_req : mode_r;
    e = '0;
    mode_end = 1'b0;
    unique case (m1)
      MODE_FORWARD: begin
        e = rf ? ((h > 0) ? 18'sd18000 - h : -18'sd18000 - h) : -h;
        mode_end = (!rf && h > -b && h < b)
                 || (rf && (h > 18'sd18000 - b || h < b - 18'sd18000));
      end
      MODE_RIGHT: begin
        e = rf ? ((h > 0) ? 18'sd9000 : 18'sd9000 + h)
               : ((h > 0) ? 18'sd9000 - h : 18'sd9000);
        mode_end = (!rf && h > 18'sd9000 - b && h < 18'sd9000 + b)
                 || (rf && h > -18'sd9000 - b && h < b - 18'sd9000);
      end
      MODE_LEFT: begin
        e = !rf ? ((h > 0) ? -18'sd9000 : -18'sd9000 - h)
                : ((h > 0) ? 18'sd9000 - h : -18'sd9000);
        mode_end = (rf && h > 18'sd9000 - b && h < 18'sd9000 + b)
                 || (!rf && h > -18'sd9000 - b && h < b - 18'sd9000);
      end
      default: ;
    endcase
    w_init = '0;
    need_atan = 1'b0;
    mode_nxt = m1;
    priority if (i_stop) begin
      mode_nxt = MODE_NONE;
    end else if (i_man) begin
      w_init = WW'(signed'({1'b0, i_lt}) - signed'({1'b0, i_rt})) <<< 16;
    end else if (m1 != MODE_NONE) begin
      need_atan = (e != 0);
      if (mode_end) mode_nxt = MODE_NONE;
    end
    if (i_clr) mode_nxt = MODE_NONE;
  end

  // cordic
  cordic_cmd_t cmd;
  logic cbusy;
  logic signed [XW-1:0] cx0, cy0, cx, cy;
  logic signed [ZW-1:0] cz0, cz;
  logic [7:0] s_eff;

  assign s_eff = (scale_r == 8'd0) ? 8'd1 : scale_r;
  assign cmd.start = start_r;
  assign cmd.vec = (state_r == ST_ATAN);
  always_comb begin
    if (state_r == ST_ATAN) begin
      cx0 = XW'(s_eff) * XW'(SCALE_X);
      cy0 = XW'(emag_r) * XW'(PI_Q13);
    end else begin
      cx0 = KINV_Q30;
      cy0 = '0;
    end
    cz0 = (state_r == ST_ATAN) ? '0 : (ZW'(a_r) <<< 16);
  end

  odmhh_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .x0(cx0), .y0(cy0), .z0(cz0),
    .busy(cbusy), .x(cx), .y(cy), .z(cz)
  );

  // quadrant turn-back
  logic signed [XW-2:0] qx, qy, bx, by;
  always_comb begin
    bx = (state_r == ST_ROT) ? cx[XW-2:0] : ONE_Q30[XW-2:0];
    by = (state_r == ST_ROT) ? cy[XW-2:0] : '0;
    unique case (q_r)
      2'd1: begin qx = -by; qy = bx; end
      2'd2: begin qx = -bx; qy = -by; end
      2'd3: begin qx = by; qy = -bx; end
      default: begin qx = bx; qy = by; end
    endcase
  end

  // stick rotation multiplier
  logic signed [SB-1:0] ma;
  logic signed [XW-2:0] mb;
  logic signed [AW-1:0] prod, sum, mag;
  logic signed [XXW-1:0] tr;
  always_comb begin
    ma = cnt_r[0] ? ry_r : rx_r;
    unique case (cnt_r)
      2'd0: mb = c_r;
      2'd1: mb = s_r;
      2'd2: mb = s_r;
      default: mb = c_r;
    endcase
    prod = AW'(ma) * AW'(mb);
    unique case (cnt_r)
      2'd1: sum = acc_r - prod;
      2'd3: sum = acc_r + prod;
      default: sum = prod;
    endcase
    mag = sum[AW-1] ? -sum : sum;
    tr = XXW'(mag >>> 30);
    if (sum[AW-1]) tr = -tr;
    if (r_r) tr = -tr;
  end

  // wheel mix
  logic signed [XXW:0] sxy;
  logic signed [VW-1:0] v, vm;
  logic signed [VW-17:0] vt, lim, vc;
  logic signed [8:0] vo;
  always_comb begin
    sxy = cnt_r[0] ? (XXW+1)'(yy_r) - (XXW+1)'(xx_r) : (XXW+1)'(yy_r) + (XXW+1)'(xx_r);
    v = (VW'(sxy) <<< 16) + (cnt_r[1] ? VW'(w_r) : -VW'(w_r));
    vm = v[VW-1] ? -v : v;
    vt = (VW-16)'(vm >>> 16);
    if (v[VW-1]) vt = -vt;
    lim = (VW-16)'(lim_r);
    vc = vt;
    if (vt < -lim) vc = -lim;
    if (vt > lim) vc = lim;
    if (half_r) vc = vc[VW-17] ? -((-vc) >>> 1) : (vc >>> 1);
    vo = 9'(cnt_r[0] ? vc : -vc);
  end

  logic [8:0] tro;
  logic signed [WW-1:0] wm;
  always_comb begin
    wm = w_r[WW-1] ? -w_r : w_r;
    tro = 9'(wm >>> 16);
    if (w_r[WW-1]) tro = -tro;
  end

  // cordic launch for the arctangent pass and the sine-cosine pass
  logic start_nxt;
  assign start_nxt = (state_r == ST_IDLE && accept && need_atan)
                   || (state_r == ST_REDUCE && a_r <= 18'sd4500 && a_r >= -18'sd4500
                       && a_r != 0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= 8'd230;
      scale_r <= 8'd70;
      band_r <= 10'd200;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DRIVE_LIMIT: lim_r <= cfg_data[7:0];
        REG_ERROR_SCALE: scale_r <= cfg_data[7:0];
        REG_SETTLE_BAND: band_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rear_r <= 1'b0;
      rl_r <= 1'b0;
      rr_r <= 1'b0;
      prev_r <= '0;
      mode_r <= MODE_NONE;
      start_r <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      start_r <= start_nxt;
      if (state_r == ST_DONE && (!out_valid_r || out_tready)) out_valid_r <= 1'b1;
      else if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            rear_r <= rf && !i_clr;
            rl_r <= rlf && !i_clr;
            rr_r <= rrf && !i_clr;
            prev_r <= i_h;
            mode_r <= mode_nxt;
            if (need_atan) begin
              state_r <= ST_ATAN;
            end else begin
              state_r <= ST_REDUCE;
            end
          end
        end
        ST_ATAN: begin
          if (!start_r && !cbusy) state_r <= ST_REDUCE;
        end
        ST_REDUCE: begin
          if (a_r <= 18'sd4500 && a_r >= -18'sd4500) begin
            if (a_r == 0) begin
              state_r <= ST_MUL;
              cnt_r <= '0;
            end else begin
              state_r <= ST_ROT;
            end
          end
        end
        ST_ROT: begin
          if (!start_r && !cbusy) begin
            state_r <= ST_MUL;
            cnt_r <= '0;
          end
        end
        ST_MUL: begin
          cnt_r <= cnt_r + 2'd1;
          if (cnt_r == 2'd3) state_r <= ST_WHEEL;
        end
        ST_WHEEL: begin
          cnt_r <= cnt_r + 2'd1;
          if (cnt_r == 2'd3) state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_r || out_tready) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        rx_r <= i_rx;
        ry_r <= i_ry;
        half_r <= i_half;
        r_r <= rf;
        neg_r <= e[17];
        emag_r <= e[17] ? 18'(-e) : 18'(e);
        a_r <= -18'(i_h);
        q_r <= '0;
        w_r <= w_init;
      end
      ST_ATAN: begin
        if (!start_r && !cbusy) w_r <= neg_r ? -WW'(cz) : WW'(cz);
      end
      ST_REDUCE: begin
        if (a_r > 18'sd4500) begin
          a_r <= a_r - 18'sd9000;
          q_r <= q_r + 2'd1;
        end else if (a_r < -18'sd4500) begin
          a_r <= a_r + 18'sd9000;
          q_r <= q_r - 2'd1;
        end else if (a_r == 0) begin
          c_r <= qx;
          s_r <= qy;
        end
      end
      ST_ROT: begin
        if (!start_r && !cbusy) begin
          c_r <= qx;
          s_r <= qy;
        end
      end
      ST_MUL: begin
        acc_r <= sum;
        if (cnt_r == 2'd1) xx_r <= tr;
        if (cnt_r == 2'd3) yy_r <= tr;
      end
      ST_WHEEL: wh_r[cnt_r] <= vo;
      ST_DONE: begin
        if (!out_valid_r || out_tready)
          out_data_r <= {2'b00, r_r, tro, wh_r[3], wh_r[2], wh_r[1], wh_r[0]};
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("tick accepted while the previous one is still at work");

  a_start_scope: assert property (@(posedge clk) disable iff (!rst_n)
    start_r |-> (state_r == ST_ATAN || state_r == ST_ROT))
    else $error("cordic launched outside a cordic pass");

  a_rear_side: assert property (@(posedge clk) disable iff (!rst_n)
    rear_r |-> (rl_r || rr_r))
    else $error("rear flag set with no rear side flag");

  a_cordic_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !cbusy)
    else $error("cordic still busy while idle");

endmodule
`default_nettype wire
